// ===== rtl/mgfd_pkg.sv =====
// Shared types and constants for the motion-gated frame decimator.
package mgfd_pkg;

    localparam int TS_W       = 48;
    localparam int RATE_W     = 32;
    localparam int TOK_W      = 24;
    localparam int THR_W      = 21;
    localparam int GAIN_W     = 12;
    localparam int RUN_W      = 8;
    localparam int SCORE_W    = 17;
    localparam int PRIO_W     = 22;
    localparam int GPROD_W    = GAIN_W + SCORE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOKEN_RATE     = 3'd0,
        CFG_FRAME_INTERVAL = 3'd1,
        CFG_BUCKET_CAP     = 3'd2,
        CFG_MOTION_THR     = 3'd3,
        CFG_FOCUS_GAIN     = 3'd4,
        CFG_MAX_DROPS      = 3'd5
    } cfg_idx_t;

    localparam logic [RATE_W-1:0] RST_TOKEN_RATE     = 32'd128849;
    localparam logic [31:0]       RST_FRAME_INTERVAL = 32'd33333;
    localparam logic [TOK_W-1:0]  RST_BUCKET_CAP     = 24'd131072;
    localparam logic [THR_W-1:0]  RST_MOTION_THR     = 21'd1311;
    localparam logic [GAIN_W-1:0] RST_FOCUS_GAIN     = 12'd1024;
    localparam logic [RUN_W-1:0]  RST_MAX_DROPS      = 8'd5;

    // Priority used for a frame that carries no motion score
    localparam logic [PRIO_W-1:0] PRIO_ONE = 22'd65536;
    localparam logic [RUN_W-1:0]  RUN_MAX  = 8'd255;

    typedef struct packed {
        logic [RATE_W-1:0] token_rate;
        logic [31:0]       frame_interval_us;
        logic [TOK_W-1:0]  bucket_cap;
        logic [THR_W-1:0]  prio_bar;
        logic [GAIN_W-1:0] focus_gain;
        logic [RUN_W-1:0]  drop_limit;
    } cfg_t;

    // One classified frame: refill already clamped to 2^TOK_W at most
    typedef struct packed {
        logic [TOK_W:0] refill;
        logic           prio_ok;
        logic           no_score;
    } dec_entry_t;

endpackage

// ===== rtl/mgfd_front.sv =====
// Front end: accepts frames, tracks timestamps, computes refill and priority.
module mgfd_front #(
    parameter int TOKEN_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mgfd_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mgfd_pkg::SCORE_W-1:0]     motion_score,
    input  logic [mgfd_pkg::SCORE_W-1:0]     focus_part,
    input  logic [mgfd_pkg::TS_W-1:0]        frame_time,
    input  logic                             timestamp_present,
    input  logic                             no_score,
    input  logic                             q_full,
    output logic                             push,
    output mgfd_pkg::dec_entry_t             push_entry
);

    localparam logic [mgfd_pkg::TOK_W:0] ONE_TOKEN =
        (mgfd_pkg::TOK_W+1)'(1) << TOKEN_FRAC_BITS;
    localparam logic [mgfd_pkg::TOK_W:0] REFILL_CLAMP =
        (mgfd_pkg::TOK_W+1)'(1) << mgfd_pkg::TOK_W;

    // timestamp tracking
    logic [mgfd_pkg::TS_W-1:0]     prev_ts_reg;
    logic                          ts_seen_reg;
    logic [mgfd_pkg::TS_W-1:0]     ts_eff;

    // stage A
    logic                          a_valid_reg;
    logic [mgfd_pkg::TS_W-1:0]     a_dt_reg;
    logic [mgfd_pkg::TS_W-1:0]     a_dt_next;
    logic                          a_one_reg;
    logic                          a_one_next;
    logic [mgfd_pkg::GPROD_W-1:0]  a_gprod_reg;
    logic [mgfd_pkg::GPROD_W-1:0]  a_gprod_next;
    logic [mgfd_pkg::SCORE_W-1:0]  a_motion_reg;
    logic                          a_no_score_reg;

    // stage B
    logic                          b_valid_reg;
    logic [63:0]                   b_plo_reg;
    logic [63:0]                   b_plo_next;
    logic [47:0]                   b_phi_reg;
    logic [47:0]                   b_phi_next;
    logic                          b_one_reg;
    logic                          b_prio_ok_reg;
    logic                          b_prio_ok_next;
    logic                          b_no_score_reg;

    logic                          accept;
    logic                          a_adv;
    logic                          a_ready;
    logic                          b_ready;
    logic [mgfd_pkg::PRIO_W-1:0]   prio;
    logic [mgfd_pkg::PRIO_W-1:0]   prio_sel;
    logic [63:0]                   refill_raw;
    logic [mgfd_pkg::TOK_W:0]      refill_q;

    assign b_ready  = !b_valid_reg || !q_full;
    assign push     = b_valid_reg && !q_full;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_adv    = a_valid_reg && b_ready;
    assign in_stall = !a_ready;
    assign accept   = in_valid && !in_stall;

    // stage A: fill in a missing timestamp, take the elapsed time and the focus gain product
    always_comb
    begin
        ts_eff = timestamp_present ? frame_time
               : prev_ts_reg + {16'b0, cfg.frame_interval_us};
        a_dt_next    = ts_eff - prev_ts_reg;
        a_one_next   = !ts_seen_reg || (ts_eff <= prev_ts_reg);
        a_gprod_next = {{mgfd_pkg::SCORE_W{1'b0}}, cfg.focus_gain}
                     * {{mgfd_pkg::GAIN_W{1'b0}}, focus_part};
    end

    // stage B: elapsed time times rate in two partial products, priority compare
    always_comb
    begin
        b_plo_next = {32'b0, a_dt_reg[31:0]} * {32'b0, cfg.token_rate};
        b_phi_next = {32'b0, a_dt_reg[47:32]} * {16'b0, cfg.token_rate};
        prio       = {5'b0, a_motion_reg} + {1'b0, a_gprod_reg[mgfd_pkg::GPROD_W-1:8]};
        prio_sel   = a_no_score_reg ? mgfd_pkg::PRIO_ONE : prio;
        b_prio_ok_next = prio_sel >= {1'b0, cfg.prio_bar};
    end

    // join the partial products; anything at or above 2^TOK_W fills any bucket
    always_comb
    begin
        refill_raw = ({32'b0, b_phi_reg[31:0]} << TOKEN_FRAC_BITS)
                   + (b_plo_reg >> (32 - TOKEN_FRAC_BITS));
        if ((b_phi_reg[47:32] != 16'b0) || (refill_raw[63:mgfd_pkg::TOK_W] != '0))
            refill_q = REFILL_CLAMP;
        else
            refill_q = refill_raw[mgfd_pkg::TOK_W:0];
        push_entry.refill   = b_one_reg ? ONE_TOKEN : refill_q;
        push_entry.prio_ok  = b_prio_ok_reg;
        push_entry.no_score = b_no_score_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ts_reg <= '0;
            ts_seen_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_ts_reg <= ts_eff;
                ts_seen_reg <= 1'b1;
            end
            if (accept)
                a_valid_reg <= 1'b1;
            else if (a_adv)
                a_valid_reg <= 1'b0;
            if (a_adv)
                b_valid_reg <= 1'b1;
            else if (push)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_dt_reg       <= a_dt_next;
            a_one_reg      <= a_one_next;
            a_gprod_reg    <= a_gprod_next;
            a_motion_reg   <= motion_score;
            a_no_score_reg <= no_score;
        end
        if (a_adv)
        begin
            b_plo_reg      <= b_plo_next;
            b_phi_reg      <= b_phi_next;
            b_one_reg      <= a_one_reg;
            b_prio_ok_reg  <= b_prio_ok_next;
            b_no_score_reg <= a_no_score_reg;
        end
    end

    // a beat held in stage B while the queue is full stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && q_full |=> b_valid_reg && $stable(b_plo_reg) && $stable(b_phi_reg))
        else $error("stage B lost its beat under back-pressure");

endmodule

// ===== rtl/mgfd_queue.sv =====
// Short queue of classified frames between front and back.
module mgfd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mgfd_pkg::dec_entry_t  push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output mgfd_pkg::dec_entry_t  pop_entry
);

    localparam int DEPTH = mgfd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mgfd_pkg::dec_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

// ===== rtl/mgfd_back.sv =====
// Back end: token bucket and drop run update, registered decision output.
module mgfd_back #(
    parameter int TOKEN_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mgfd_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    input  mgfd_pkg::dec_entry_t           q_entry,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           keep,
    output logic [mgfd_pkg::RUN_W-1:0]     drop_run_after,
    output logic [mgfd_pkg::TOK_W-1:0]     tokens_after
);

    localparam logic [mgfd_pkg::TOK_W:0] ONE_TOKEN =
        (mgfd_pkg::TOK_W+1)'(1) << TOKEN_FRAC_BITS;

    logic [mgfd_pkg::TOK_W-1:0] level_reg;
    logic [mgfd_pkg::TOK_W-1:0] level_next;
    logic [mgfd_pkg::RUN_W-1:0] run_reg;
    logic [mgfd_pkg::RUN_W-1:0] run_next;
    logic                       out_valid_reg;
    logic                       out_keep_reg;
    logic [mgfd_pkg::RUN_W-1:0] out_run_reg;
    logic [mgfd_pkg::TOK_W-1:0] out_tokens_reg;

    logic                       out_ready;
    logic [mgfd_pkg::TOK_W:0]   level_sum;
    logic [mgfd_pkg::TOK_W-1:0] capped;
    logic [mgfd_pkg::TOK_W:0]   spent;
    logic                       has_token;
    logic                       keep_dec;

    assign out_ready      = !out_valid_reg || !out_stall;
    assign pop            = q_valid && out_ready;
    assign out_valid      = out_valid_reg;
    assign keep           = out_keep_reg;
    assign drop_run_after = out_run_reg;
    assign tokens_after   = out_tokens_reg;

    always_comb
    begin
        // refill, cap, decide, spend
        level_sum = {1'b0, level_reg} + q_entry.refill;
        capped    = (level_sum > {1'b0, cfg.bucket_cap})
                  ? cfg.bucket_cap : level_sum[mgfd_pkg::TOK_W-1:0];
        has_token = {1'b0, capped} >= ONE_TOKEN;
        keep_dec  = (run_reg >= cfg.drop_limit)
                  || (q_entry.prio_ok && has_token);
        spent     = {1'b0, capped} - ONE_TOKEN;
        if (keep_dec)
        begin
            level_next = has_token ? spent[mgfd_pkg::TOK_W-1:0] : '0;
            run_next   = '0;
        end
        else
        begin
            level_next = capped;
            run_next   = (run_reg == mgfd_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                level_reg <= level_next;
                run_reg   <= run_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_keep_reg   <= keep_dec || q_entry.no_score;
            out_run_reg    <= run_next;
            out_tokens_reg <= level_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && keep_dec |=> run_reg == '0)
        else $error("drop run not cleared on a keep");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !keep_dec && run_reg != mgfd_pkg::RUN_MAX
        |=> run_reg == $past(run_reg) + 1'b1)
        else $error("drop run did not advance on a drop");

endmodule

// ===== rtl/motion_gated_frame_decimator.sv =====
// Top level of the motion-gated frame decimator: configuration and wiring.
// One frame beat is accepted per clock while in_stall is low, and one decision
// beat comes out per frame, in order. A frame passes through two front stages
// (timestamp fill-in and elapsed time, then the split rate multiply and
// priority compare), a two-entry queue, and the output register of the back
// end. The token bucket and drop run are updated in the back end as each beat
// is popped, at a sustained rate of one frame per clock while the output side
// does not stall. Each side stalls on its own; the queue soaks up the
// difference. Configuration registers are written through a plain write port
// and should only change while no frame is in flight.
module motion_gated_frame_decimator #(
    parameter int TOKEN_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mgfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mgfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mgfd_pkg::SCORE_W-1:0]      motion_score,
    input  logic [mgfd_pkg::SCORE_W-1:0]      focus_part,
    input  logic [mgfd_pkg::TS_W-1:0]         frame_time,
    input  logic                              timestamp_present,
    input  logic                              no_score,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              keep,
    output logic [mgfd_pkg::RUN_W-1:0]        drop_run_after,
    output logic [mgfd_pkg::TOK_W-1:0]        tokens_after
);

    mgfd_pkg::cfg_t       cfg_reg;
    mgfd_pkg::dec_entry_t push_entry;
    mgfd_pkg::dec_entry_t pop_entry;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.token_rate        <= mgfd_pkg::RST_TOKEN_RATE;
            cfg_reg.frame_interval_us <= mgfd_pkg::RST_FRAME_INTERVAL;
            cfg_reg.bucket_cap        <= mgfd_pkg::RST_BUCKET_CAP;
            cfg_reg.prio_bar          <= mgfd_pkg::RST_MOTION_THR;
            cfg_reg.focus_gain        <= mgfd_pkg::RST_FOCUS_GAIN;
            cfg_reg.drop_limit        <= mgfd_pkg::RST_MAX_DROPS;
        end
        else if (cfg_write)
        begin
            case (mgfd_pkg::cfg_idx_t'(cfg_index))
                mgfd_pkg::CFG_TOKEN_RATE:
                    cfg_reg.token_rate <= cfg_data;
                mgfd_pkg::CFG_FRAME_INTERVAL:
                    cfg_reg.frame_interval_us <= cfg_data;
                mgfd_pkg::CFG_BUCKET_CAP:
                    cfg_reg.bucket_cap <= cfg_data[mgfd_pkg::TOK_W-1:0];
                mgfd_pkg::CFG_MOTION_THR:
                    cfg_reg.prio_bar <= cfg_data[mgfd_pkg::THR_W-1:0];
                mgfd_pkg::CFG_FOCUS_GAIN:
                    cfg_reg.focus_gain <= cfg_data[mgfd_pkg::GAIN_W-1:0];
                mgfd_pkg::CFG_MAX_DROPS:
                    cfg_reg.drop_limit <= cfg_data[mgfd_pkg::RUN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    mgfd_front #(
        .TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .motion_score      (motion_score),
        .focus_part        (focus_part),
        .frame_time        (frame_time),
        .timestamp_present (timestamp_present),
        .no_score          (no_score),
        .q_full            (q_full),
        .push              (push),
        .push_entry        (push_entry)
    );

    mgfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_valid),
        .pop_entry  (pop_entry)
    );

    mgfd_back #(
        .TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_entry        (pop_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .keep           (keep),
        .drop_run_after (drop_run_after),
        .tokens_after   (tokens_after)
    );

endmodule
